// ----- design/ost_pkg.sv -----
package ost_pkg;

  localparam int DELAY_BITS_DEF = 32;
  localparam int RES_BITS_DEF   = 16;
  localparam int DEFAULT_RES    = 10;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ARM    = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_ACK    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_PENDING = 2'd2,
    ST_EARLY   = 2'd3
  } status_t;

endpackage

// ----- design/ost_div.sv -----
module ost_div import ost_pkg::*; #(
  parameter int NUM_BITS = DELAY_BITS_DEF + 1,
  parameter int DEN_BITS = RES_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quo
);

  localparam int CW = $clog2(NUM_BITS + 1);

  logic                busy_r;
  logic                done_r;
  logic [CW-1:0]       cnt_r;
  logic [DEN_BITS-1:0] rem_r;
  logic [DEN_BITS-1:0] den_r;
  logic [NUM_BITS-1:0] quo_r;
  logic [DEN_BITS:0]   rem_sh;
  logic [DEN_BITS:0]   rem_sub;
  logic                q_bit;

  assign rem_sh  = {rem_r, quo_r[NUM_BITS-1]};
  assign q_bit   = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= q_bit ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
      quo_r <= {quo_r[NUM_BITS-2:0], q_bit};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- design/one_shot_timer_arm_ack.sv -----
// One-shot down-counting timer driven by command beats.
// Input channel (in_valid/in_ready): in_kind selects tick, arm, cancel or
// acknowledge; in_delay_ms is the requested delay, used by arm only.
// Output channel (out_valid/out_ready): one result beat per input beat, giving
// the status and the timer state after the command.
// Configuration channel (cfg_valid/cfg_ready): writes the resolution in
// milliseconds per tick; zero is taken as ten. It is always ready.
// Tick, cancel, acknowledge and refused arms go from acceptance through S_HOLD
// to the output register. An accepted arm runs the restoring divider, one quotient
// bit per cycle over max(DELAY_BITS, RES_BITS) + 1 bits, in S_DIV and then passes
// through S_HOLD to the output register. One command is in flight at a time.
// A new beat is accepted as soon as the previous result has moved into the
// output register, even while that result waits for out_ready.
// Reset clears the timer, empties the output register and sets the resolution
// to ten. A stalled receiver holds the result beat steady and, once the next
// command has finished, blocks further input until the output is taken.
module one_shot_timer_arm_ack import ost_pkg::*; #(
  parameter int DELAY_BITS = DELAY_BITS_DEF,
  parameter int RES_BITS   = RES_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic [DELAY_BITS-1:0] in_delay_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic                  out_active,
  output logic                  out_expired,
  output logic [DELAY_BITS-1:0] out_remaining,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RES_BITS-1:0]   cfg_data
);

  localparam int NW = ((DELAY_BITS > RES_BITS) ? DELAY_BITS : RES_BITS) + 1;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_HOLD} state_t;

  state_t                state_r;
  logic [RES_BITS-1:0]   res_r;
  logic                  armed_r;
  logic                  sig_r;
  logic [DELAY_BITS-1:0] count_r;
  status_t               pend_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic                  out_active_r;
  logic                  out_expired_r;
  logic [DELAY_BITS-1:0] out_remaining_r;

  logic [RES_BITS-1:0]   res_eff;
  logic [NW-1:0]         div_num;
  logic                  div_start;
  logic                  div_done;
  logic [NW-1:0]         div_quo;
  logic                  accept;
  kind_t                 kind;

  assign res_eff   = (res_r == '0) ? RES_BITS'(DEFAULT_RES) : res_r;
  assign div_num   = NW'(in_delay_ms) + NW'(res_eff) - NW'(1);
  assign accept    = in_valid && in_ready;
  assign kind      = kind_t'(in_kind);
  assign div_start = accept && (kind == KIND_ARM) && (in_delay_ms != '0) && !armed_r;

  ost_div #(
    .NUM_BITS(NW),
    .DEN_BITS(RES_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (res_eff),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_r       <= RES_BITS'(DEFAULT_RES);
      armed_r     <= 1'b0;
      sig_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        res_r <= cfg_data;
      end
      if (out_valid_r && out_ready && (state_r != S_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pend_r  <= ST_OK;
            state_r <= S_HOLD;
            unique case (kind)
              KIND_TICK: begin
                if (armed_r && count_r != '0) begin
                  count_r <= count_r - 1'b1;
                  if (count_r == DELAY_BITS'(1)) begin
                    sig_r <= 1'b1;
                  end
                end
              end
              KIND_ARM: begin
                if (in_delay_ms == '0) begin
                  pend_r <= ST_INVALID;
                end else if (armed_r) begin
                  pend_r <= ST_PENDING;
                end else begin
                  state_r <= S_DIV;
                end
              end
              KIND_CANCEL, KIND_ACK: begin
                if (!armed_r) begin
                  pend_r <= ST_INVALID;
                end else begin
                  if (kind == KIND_ACK && count_r != '0) begin
                    pend_r <= ST_EARLY;
                  end
                  armed_r <= 1'b0;
                  sig_r   <= 1'b0;
                  count_r <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            armed_r <= 1'b1;
            sig_r   <= 1'b0;
            count_r <= div_quo[DELAY_BITS-1:0];
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r     <= 1'b1;
            out_status_r    <= pend_r;
            out_active_r    <= armed_r;
            out_expired_r   <= sig_r;
            out_remaining_r <= count_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_active    = out_active_r;
  assign out_expired   = out_expired_r;
  assign out_remaining = out_remaining_r;

endmodule
